FILE: rtl/fcr_pkg.sv
// Shared types, widths and codes for the false position cubic root unit.
package fcr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_STEPS = 64;
    localparam int X_W       = 24;
    localparam int F_W       = 40;
    localparam int RES_W     = 48;
    localparam int TOL_W     = 32;
    localparam int STEP_W    = 7;
    localparam int DIV_BITS  = 25;
    localparam int CNT_W     = 5;
    localparam int SQ_W      = 31;
    localparam int PROD_W    = 56;

    localparam logic [TOL_W-1:0] TOL_RESET = 32'd66;

    // operand select for the cubic evaluator
    localparam logic [1:0] EV_X0 = 2'd0;
    localparam logic [1:0] EV_X1 = 2'd1;
    localparam logic [1:0] EV_X2 = 2'd2;

    // result select
    localparam logic [1:0] OSEL_X0_ZERO = 2'd0;
    localparam logic [1:0] OSEL_X1_ZERO = 2'd1;
    localparam logic [1:0] OSEL_X0_F0   = 2'd2;
    localparam logic [1:0] OSEL_X2_F2   = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_CONVERGED = 2'd0;
    localparam logic [1:0] STAT_NO_BRACKET = 2'd1;
    localparam logic [1:0] STAT_LIMIT     = 2'd2;

    typedef struct packed {
        logic signed [X_W-1:0] guess_a;
        logic signed [X_W-1:0] guess_b;
    } t_in_word;

    typedef struct packed {
        logic signed [X_W-1:0]   root;
        logic signed [RES_W-1:0] residual;
        logic [STEP_W-1:0]       steps;
        logic [1:0]              status;
    } t_out_word;

    typedef struct packed {
        logic       load_in;
        logic [1:0] ev_sel;
        logic       sq_en;
        logic       mul_en;
        logic       f_wr;
        logic       div_init;
        logic       div_step;
        logic       x2_wr;
        logic       upd;
        logic       out_load;
        logic [1:0] out_sel;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic f0_zero;
        logic f1_zero;
        logic same_sign;
        logic conv;
        logic n_max;
    } t_stat;

endpackage

FILE: rtl/fcr_cubic.sv
// Two-stage evaluator of f(x) = x^3 - 2x - 5 in fixed point.
module fcr_cubic (
    input  logic                              i_clk,
    input  logic                              i_sq_en,
    input  logic                              i_mul_en,
    input  logic signed [fcr_pkg::X_W-1:0]    i_x,
    output logic signed [fcr_pkg::F_W-1:0]    o_f
);

    logic [fcr_pkg::SQ_W-1:0]            r_sq;
    logic signed [fcr_pkg::X_W-1:0]      r_xa;
    logic signed [fcr_pkg::X_W-1:0]      r_xb;
    logic signed [fcr_pkg::PROD_W-1:0]   r_prod;
    logic signed [2*fcr_pkg::X_W-1:0]    sq_full;
    logic signed [fcr_pkg::F_W-1:0]      cube;
    logic signed [fcr_pkg::F_W-1:0]      two_x;

    assign sq_full = i_x * i_x;

    always_ff @(posedge i_clk) begin
        if (i_sq_en) begin
            // square is never negative: drop the fraction, keep the magnitude
            r_sq <= sq_full[fcr_pkg::FRAC_BITS +: fcr_pkg::SQ_W];
            r_xa <= i_x;
        end
        if (i_mul_en) begin
            r_prod <= $signed({1'b0, r_sq}) * r_xa;
            r_xb   <= r_xa;
        end
    end

    // arithmetic shift: floor toward minus infinity
    assign cube  = r_prod[fcr_pkg::FRAC_BITS +: fcr_pkg::F_W];
    assign two_x = fcr_pkg::F_W'(r_xb) <<< 1;
    assign o_f   = cube - two_x - fcr_pkg::F_W'(5 << fcr_pkg::FRAC_BITS);

endmodule

FILE: rtl/fcr_dpath.sv
// Datapath: bracket registers, cubic evaluator, long divider and result register.
module fcr_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fcr_pkg::t_in_word              i_in_word,
    input  logic                           i_cfg_we,
    input  logic [fcr_pkg::TOL_W-1:0]      i_cfg_data,
    input  fcr_pkg::t_cmd                  i_cmd,
    output fcr_pkg::t_stat                 o_stat,
    output fcr_pkg::t_out_word             o_out_word
);

    localparam int A_W = fcr_pkg::DIV_BITS;
    localparam int C_W = fcr_pkg::F_W + 1;
    localparam int T_W = fcr_pkg::F_W + 3;

    function automatic logic [fcr_pkg::F_W-1:0] mag(input logic signed [fcr_pkg::F_W-1:0] v);
        mag = v[fcr_pkg::F_W-1] ? fcr_pkg::F_W'(-v) : fcr_pkg::F_W'(v);
    endfunction

    logic [fcr_pkg::TOL_W-1:0]          r_tol;
    logic signed [fcr_pkg::X_W-1:0]     r_x0, r_x1, r_x2;
    logic signed [fcr_pkg::F_W-1:0]     r_f0, r_f1, r_f2;
    logic [fcr_pkg::STEP_W-1:0]         r_n;
    logic [A_W-1:0]                     r_a;
    logic [fcr_pkg::F_W-1:0]            r_b;
    logic [C_W-1:0]                     r_c;
    logic [C_W-1:0]                     r_r;
    logic [A_W-1:0]                     r_q;
    logic                               r_dneg;
    fcr_pkg::t_out_word                 r_out;

    logic signed [fcr_pkg::X_W-1:0]     ev_x;
    logic signed [fcr_pkg::F_W-1:0]     f_new;
    logic signed [fcr_pkg::X_W:0]       d;
    logic [T_W-1:0]                     t;
    logic [T_W-1:0]                     c1, c2;
    logic [C_W-1:0]                     n_r;
    logic [1:0]                         k;
    logic signed [fcr_pkg::X_W-1:0]     q_x;

    always_comb begin
        case (i_cmd.ev_sel)
            fcr_pkg::EV_X0: ev_x = r_x0;
            fcr_pkg::EV_X1: ev_x = r_x1;
            default:        ev_x = r_x2;
        endcase
    end

    fcr_cubic u_cubic (
        .i_clk    (i_clk),
        .i_sq_en  (i_cmd.sq_en),
        .i_mul_en (i_cmd.mul_en),
        .i_x      (ev_x),
        .o_f      (f_new)
    );

    assign d = {r_x0[fcr_pkg::X_W-1], r_x0} - {r_x1[fcr_pkg::X_W-1], r_x1};

    // one quotient bit per cycle; partial remainder stays below c, so t < 3c
    always_comb begin
        t  = {r_r, 1'b0} + (r_a[A_W-1] ? T_W'(r_b) : T_W'(0));
        c1 = T_W'(r_c);
        c2 = T_W'({r_c, 1'b0});
        if (t >= c2) begin
            n_r = C_W'(t - c2);
            k   = 2'd2;
        end else if (t >= c1) begin
            n_r = C_W'(t - c1);
            k   = 2'd1;
        end else begin
            n_r = C_W'(t);
            k   = 2'd0;
        end
    end

    assign q_x = $signed(r_q[fcr_pkg::X_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= fcr_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x0 <= i_in_word.guess_a;
            r_x1 <= i_in_word.guess_b;
            r_n  <= '0;
        end
        if (i_cmd.f_wr) begin
            case (i_cmd.ev_sel)
                fcr_pkg::EV_X0: r_f0 <= f_new;
                fcr_pkg::EV_X1: r_f1 <= f_new;
                default:        r_f2 <= f_new;
            endcase
        end
        if (i_cmd.div_init) begin
            r_a    <= A_W'(d[fcr_pkg::X_W] ? -d : d);
            r_b    <= mag(r_f0);
            r_c    <= C_W'(mag(r_f0)) + C_W'(mag(r_f1));
            r_r    <= '0;
            r_q    <= '0;
            r_dneg <= d[fcr_pkg::X_W];
        end
        if (i_cmd.div_step) begin
            r_a <= {r_a[A_W-2:0], 1'b0};
            r_r <= n_r;
            r_q <= {r_q[A_W-2:0], 1'b0} + A_W'(k);
        end
        if (i_cmd.x2_wr) begin
            r_x2 <= r_dneg ? r_x0 + q_x : r_x0 - q_x;
        end
        if (i_cmd.upd) begin
            // keep the end pair that still changes sign
            if ((r_f0 < 0 && r_f2 > 0) || (r_f0 > 0 && r_f2 < 0)) begin
                r_x1 <= r_x2;
                r_f1 <= r_f2;
            end else begin
                r_x0 <= r_x2;
                r_f0 <= r_f2;
            end
            r_n <= r_n + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.steps  <= r_n;
            r_out.status <= i_cmd.status;
            // f is 40 bits wide, so widening it to the 48-bit residual is a sign extension
            case (i_cmd.out_sel)
                fcr_pkg::OSEL_X0_ZERO: begin
                    r_out.root     <= r_x0;
                    r_out.residual <= '0;
                end
                fcr_pkg::OSEL_X1_ZERO: begin
                    r_out.root     <= r_x1;
                    r_out.residual <= '0;
                end
                fcr_pkg::OSEL_X0_F0: begin
                    r_out.root     <= r_x0;
                    r_out.residual <= fcr_pkg::RES_W'(r_f0);
                end
                default: begin
                    r_out.root     <= r_x2;
                    r_out.residual <= fcr_pkg::RES_W'(r_f2);
                end
            endcase
        end
    end

    assign o_stat.f0_zero   = (r_f0 == '0);
    assign o_stat.f1_zero   = (r_f1 == '0);
    assign o_stat.same_sign = (r_f0[fcr_pkg::F_W-1] == r_f1[fcr_pkg::F_W-1]);
    assign o_stat.conv      = (mag(r_f2) <= fcr_pkg::F_W'(r_tol));
    assign o_stat.n_max     = (r_n == fcr_pkg::STEP_W'(fcr_pkg::MAX_STEPS));
    assign o_out_word       = r_out;

endmodule

FILE: rtl/fcr_ctrl.sv
// Controller: sequences evaluation, division and bracket update per word.
module fcr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  fcr_pkg::t_stat     i_stat,
    output fcr_pkg::t_cmd      o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQ    = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_WR    = 4'd3;
    localparam logic [3:0] ST_CHK   = 4'd4;
    localparam logic [3:0] ST_DINIT = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_X2    = 4'd7;
    localparam logic [3:0] ST_UPD   = 4'd8;
    localparam logic [3:0] ST_DEC   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0]                 r_state, n_state;
    logic [1:0]                 r_ev, n_ev;
    logic [fcr_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ev    <= fcr_pkg::EV_X0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ev    <= n_ev;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ev    = r_ev;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.ev_sel = r_ev;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_ev    = fcr_pkg::EV_X0;
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.sq_en = 1'b1;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = ST_WR;
            end
            ST_WR: begin
                o_cmd.f_wr = 1'b1;
                case (r_ev)
                    fcr_pkg::EV_X0: begin
                        n_ev    = fcr_pkg::EV_X1;
                        n_state = ST_SQ;
                    end
                    fcr_pkg::EV_X1: n_state = ST_CHK;
                    default:        n_state = ST_UPD;
                endcase
            end
            ST_CHK: begin
                if (i_stat.f0_zero) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = fcr_pkg::OSEL_X0_ZERO;
                    o_cmd.status   = fcr_pkg::STAT_CONVERGED;
                    n_state = ST_OUT;
                end else if (i_stat.f1_zero) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = fcr_pkg::OSEL_X1_ZERO;
                    o_cmd.status   = fcr_pkg::STAT_CONVERGED;
                    n_state = ST_OUT;
                end else if (i_stat.same_sign) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = fcr_pkg::OSEL_X0_F0;
                    o_cmd.status   = fcr_pkg::STAT_NO_BRACKET;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DINIT;
                end
            end
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == fcr_pkg::CNT_W'(fcr_pkg::DIV_BITS - 1)) begin
                    n_state = ST_X2;
                end
            end
            ST_X2: begin
                o_cmd.x2_wr = 1'b1;
                n_ev    = fcr_pkg::EV_X2;
                n_state = ST_SQ;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = ST_DEC;
            end
            ST_DEC: begin
                if (i_stat.conv) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = fcr_pkg::OSEL_X2_F2;
                    o_cmd.status   = fcr_pkg::STAT_CONVERGED;
                    n_state = ST_OUT;
                end else if (i_stat.n_max) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = fcr_pkg::OSEL_X2_F2;
                    o_cmd.status   = fcr_pkg::STAT_LIMIT;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DINIT;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

endmodule

FILE: rtl/false_position_cubic_root_unit.sv
// Top level of the false position root finder for x^3 - 2x - 5.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one word with two
//   signed Q8.16 guesses. Output channel (o_out_valid / i_out_ready / o_out_word)
//   returns one word per input: root, residual, step count and status.
//   Configuration: pulse i_cfg_we with i_cfg_data to set the tolerance (Q16.16,
//   unsigned); write it only while the unit is idle.
// Sequencing:
//   One word is worked on at a time. Both guesses are evaluated and the bracket
//   is checked; then each false position iteration runs divider setup, the
//   bit-serial long divider, the new estimate, its cubic evaluation (square,
//   multiply, write), the bracket update and the stop check. A word runs up to
//   64 iterations, and the input side reopens in the cycle after the result
//   word is taken.
// Reset:
//   Synchronous, active low. Clears the sequencer to idle and loads the
//   tolerance with 66 (about 0.001).
// Stall:
//   While i_out_ready is low the result word holds stable on o_out_word and no
//   new input word is taken.
module false_position_cubic_root_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  fcr_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output fcr_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_we,
    input  logic [fcr_pkg::TOL_W-1:0]      i_cfg_data
);

    fcr_pkg::t_cmd   cmd;
    fcr_pkg::t_stat  stat;

    // sequencer: owns both handshakes, drives the datapath by command
    fcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: bracket, cubic, divider, tolerance and result word
    fcr_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_word (o_out_word)
    );

endmodule
